@@ src/gaussian_blur_3x3_assert.svh @@
// Assertion macros used by the gaussian blur top level.
`ifndef GAUSSIAN_BLUR_3X3_ASSERT_SVH
`define GAUSSIAN_BLUR_3X3_ASSERT_SVH
`ifndef SYNTHESIS
`define GB3_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gb3 same-cycle check failed");
`define GB3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gb3 next-cycle check failed");
`else
`define GB3_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define GB3_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ src/gb3_pkg.sv @@
// Types, constants and the 1-2-1 kernel function for the gaussian blur block.
`timescale 1ns / 1ps
package gb3_pkg;

    localparam int unsigned PIX_W      = 8;
    localparam int unsigned CFG_W      = 11;
    localparam int unsigned ROW_W      = 10;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = 2;
    localparam int unsigned FIFO_CNT_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd600;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd400;
    localparam logic [CFG_W-1:0] MIN_DIM          = 11'd3;
    localparam logic [CFG_W-1:0] MAX_HEIGHT       = 11'd1024;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic             op;
        logic [PIX_W-1:0] pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             end_of_frame;
    } t_out_item;

    // one window column, index 0 is the oldest row
    typedef logic [2:0][PIX_W-1:0] t_col;

    typedef enum logic [1:0] {
        S_RUN,
        S_MUL,
        S_DIV
    } t_geo_state;

    // floor of the 1-2-1 x 1-2-1 weighted sum over 16
    function automatic logic [PIX_W-1:0] blur_121(input t_col a, input t_col b, input t_col c);
        logic [PIX_W+1:0] va;
        logic [PIX_W+1:0] vb;
        logic [PIX_W+1:0] vc;
        logic [PIX_W+3:0] sum;
        va  = {2'b00, a[0]} + {1'b0, a[1], 1'b0} + {2'b00, a[2]};
        vb  = {2'b00, b[0]} + {1'b0, b[1], 1'b0} + {2'b00, b[2]};
        vc  = {2'b00, c[0]} + {1'b0, c[1], 1'b0} + {2'b00, c[2]};
        sum = {2'b00, va} + {1'b0, vb, 1'b0} + {2'b00, vc};
        return sum[PIX_W+3:4];
    endfunction

endpackage

@@ src/gb3_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module gb3_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old word when the same address is written
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/gb3_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module gb3_div #(
    parameter int unsigned NW = 22,
    parameter int unsigned DW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [NW-1:0] o_quotient,
    output logic [DW-1:0] o_remainder
);

    localparam int unsigned CNT_W = $clog2(NW);

    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    n_rem;
    logic [NW-1:0]    r_quo;
    logic [NW-1:0]    n_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DW:0]      shifted;
    logic [DW:0]      diff;
    logic             ge;

    always_comb begin
        shifted = {r_rem, r_quo[NW-1]};
        diff    = shifted - {1'b0, i_divisor};
        ge      = (shifted >= {1'b0, i_divisor});
        n_rem   = ge ? diff[DW-1:0] : shifted[DW-1:0];
        n_quo   = {r_quo[NW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend bits shift out of the top of r_quo as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

@@ src/gaussian_blur_3x3.sv @@
// 3x3 gaussian blur (1-2-1 kernel) on a raster grey pixel stream, top level.
// A result passes through the stage 1 registers and then into the output queue.
// Throughput: one request per cycle when not stalled; one line RAM read and write per pixel.
// After a frame geometry write, requests are stalled while the product is formed and the serial
// divider splits the output position.
// Reset is synchronous, active low; the line RAM is not cleared.
`timescale 1ns / 1ps
`include "gaussian_blur_3x3_assert.svh"
module gaussian_blur_3x3 #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  gb3_pkg::t_in_item                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output gb3_pkg::t_out_item               o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [gb3_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gb3_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HW = gb3_pkg::CFG_W;
    localparam int unsigned RW = gb3_pkg::ROW_W;
    localparam int unsigned TW = WW + HW;
    localparam int unsigned PW = gb3_pkg::PIX_W;
    localparam int unsigned FD = gb3_pkg::FIFO_DEPTH;
    localparam int unsigned FA = gb3_pkg::FIFO_AW;
    localparam int unsigned FC = gb3_pkg::FIFO_CNT_W;
    localparam int unsigned RST_W = (int'(gb3_pkg::FRAME_WIDTH_RST) > MAX_WIDTH) ?
                                    MAX_WIDTH : int'(gb3_pkg::FRAME_WIDTH_RST);
    localparam logic [TW-1:0] RST_TOTAL = TW'(RST_W * int'(gb3_pkg::FRAME_HEIGHT_RST));

    // configuration and geometry
    logic [HW-1:0]       r_frame_width;
    logic [HW-1:0]       r_frame_height;
    logic [WW-1:0]       w_eff;
    logic [HW-1:0]       h_eff;
    logic [TW-1:0]       r_total;
    logic                cfg_wr;
    gb3_pkg::t_geo_state r_state;
    gb3_pkg::t_geo_state n_state;
    logic                div_start;
    logic                div_done;
    logic                load_geo;
    logic [TW-1:0]       div_quo;
    logic [WW-1:0]       div_rem;

    // position counters
    logic [CW-1:0] r_in_col, n_in_col;
    logic [RW-1:0] r_in_row, n_in_row;
    logic [WW-1:0] r_pending, n_pending;
    logic [TW-1:0] r_out_pos, n_out_pos;
    logic [CW-1:0] r_ocol, n_ocol;
    logic [TW-1:0] r_orow, n_orow;

    // request decode
    logic          acc;
    logic          is_pix;
    logic [WW:0]   pend_inc;
    logic          emit_pix;
    logic          flush_ok;
    logic          emit_now;
    logic          acc_emit;
    logic          row1_sel;
    logic          border;
    logic          eof_now;
    logic [TW-1:0] pos_inc;
    logic [WW-1:0] ocol_inc;
    logic [WW-1:0] in_col_inc;
    logic [HW-1:0] in_row_inc;
    logic [CW-1:0] rd_addr;

    // stage 1
    logic          r_s1_valid;
    logic          r_s1_pix;
    logic          r_s1_emit;
    logic          r_s1_border;
    logic          r_s1_eof;
    logic          r_s1_row1;
    logic [PW-1:0] r_s1_px;
    logic [CW-1:0] r_s1_col;
    logic          r_byp;
    logic [2*PW-1:0] r_byp_data;
    logic [2*PW-1:0] ram_q;
    logic [2*PW-1:0] line_q;
    logic [PW-1:0] up1;
    logic [PW-1:0] up2;
    gb3_pkg::t_col nc;
    gb3_pkg::t_col r_win_c0;
    gb3_pkg::t_col r_win_c1;
    gb3_pkg::t_col r_win_c2;
    logic          wr_en;
    logic [2*PW-1:0] wr_data;
    gb3_pkg::t_out_item res;

    // output queue
    gb3_pkg::t_out_item r_fifo [0:FD-1];
    logic [FA-1:0] r_wr_ptr;
    logic [FA-1:0] r_rd_ptr;
    logic [FC-1:0] r_cnt;
    logic          push;
    logic          pop;
    logic [FC:0]   occ;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= gb3_pkg::FRAME_WIDTH_RST;
            r_frame_height <= gb3_pkg::FRAME_HEIGHT_RST;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                gb3_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                gb3_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        if (r_frame_width < gb3_pkg::MIN_DIM) begin
            w_eff = WW'(gb3_pkg::MIN_DIM);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_frame_width);
        end
        if (r_frame_height < gb3_pkg::MIN_DIM) begin
            h_eff = gb3_pkg::MIN_DIM;
        end else if (r_frame_height > gb3_pkg::MAX_HEIGHT) begin
            h_eff = gb3_pkg::MAX_HEIGHT;
        end else begin
            h_eff = r_frame_height;
        end
    end

    // geometry update: product, then row/column split of the output position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gb3_pkg::S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        load_geo  = 1'b0;
        unique case (r_state)
            gb3_pkg::S_RUN: begin
                if (cfg_wr) begin
                    n_state = gb3_pkg::S_MUL;
                end
            end
            gb3_pkg::S_MUL: begin
                if (!cfg_wr) begin
                    div_start = 1'b1;
                    n_state   = gb3_pkg::S_DIV;
                end
            end
            gb3_pkg::S_DIV: begin
                if (cfg_wr) begin
                    n_state = gb3_pkg::S_MUL;
                end else if (div_done) begin
                    load_geo = 1'b1;
                    n_state  = gb3_pkg::S_RUN;
                end
            end
            default: n_state = gb3_pkg::S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= RST_TOTAL;
        end else if (r_state == gb3_pkg::S_MUL) begin
            r_total <= TW'(w_eff * h_eff);
        end
    end

    gb3_div #(
        .NW(TW),
        .DW(WW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_out_pos),
        .i_divisor  (w_eff),
        .o_done     (div_done),
        .o_quotient (div_quo),
        .o_remainder(div_rem)
    );

    // request decode and counter update
    always_comb begin
        acc        = i_in_valid && !o_in_stall;
        is_pix     = (i_in_data.op == gb3_pkg::OP_PIXEL);
        pend_inc   = {1'b0, r_pending} + (WW + 1)'(1);
        emit_pix   = (pend_inc > {1'b0, w_eff});
        flush_ok   = (r_in_col == '0) && (r_in_row == '0) && (r_pending != '0);
        emit_now   = is_pix ? emit_pix : flush_ok;
        acc_emit   = acc && emit_now;
        row1_sel   = (r_pending > w_eff);
        border     = (r_orow == '0) || (r_orow >= TW'(h_eff - HW'(1))) ||
                     (r_ocol == '0) || (WW'(r_ocol) >= (w_eff - WW'(1)));
        eof_now    = (r_out_pos == (r_total - TW'(1)));
        pos_inc    = r_out_pos + TW'(1);
        ocol_inc   = WW'(r_ocol) + WW'(1);
        in_col_inc = WW'(r_in_col) + WW'(1);
        in_row_inc = {1'b0, r_in_row} + HW'(1);
        rd_addr    = is_pix ? r_in_col : r_ocol;

        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_pending = r_pending;
        n_out_pos = r_out_pos;
        n_ocol    = r_ocol;
        n_orow    = r_orow;

        if (acc) begin
            if (is_pix) begin
                if (in_col_inc >= w_eff) begin
                    n_in_col = '0;
                    n_in_row = (in_row_inc >= h_eff) ? '0 : RW'(in_row_inc);
                end else begin
                    n_in_col = CW'(in_col_inc);
                end
                n_pending = emit_pix ? r_pending : WW'(pend_inc);
            end else if (flush_ok) begin
                n_pending = r_pending - WW'(1);
            end
        end
        if (acc_emit) begin
            if (pos_inc >= r_total) begin
                n_out_pos = '0;
                n_ocol    = '0;
                n_orow    = '0;
            end else begin
                n_out_pos = pos_inc;
                if (ocol_inc >= w_eff) begin
                    n_ocol = '0;
                    n_orow = r_orow + TW'(1);
                end else begin
                    n_ocol = CW'(ocol_inc);
                end
            end
        end
        if (load_geo) begin
            n_ocol = CW'(div_rem);
            n_orow = div_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_pending  <= '0;
            r_out_pos  <= '0;
            r_ocol     <= '0;
            r_orow     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_pending  <= n_pending;
            r_out_pos  <= n_out_pos;
            r_ocol     <= n_ocol;
            r_orow     <= n_orow;
            r_s1_valid <= acc;
        end
    end

    // stage 1 payload; bypass covers a read of the word being written this edge
    always_ff @(posedge i_clk) begin
        r_s1_pix    <= is_pix;
        r_s1_emit   <= emit_now;
        r_s1_border <= border;
        r_s1_eof    <= eof_now;
        r_s1_row1   <= row1_sel;
        r_s1_px     <= i_in_data.pixel_in;
        r_s1_col    <= r_in_col;
        r_byp       <= wr_en && (r_s1_col == rd_addr);
        r_byp_data  <= wr_data;
    end

    gb3_ram #(
        .WIDTH(2 * PW),
        .DEPTH(MAX_WIDTH)
    ) u_line_ram (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(r_s1_col),
        .i_wdata(wr_data),
        .i_raddr(rd_addr),
        .o_rdata(ram_q)
    );

    // line word: upper byte two rows up, lower byte one row up
    always_comb begin
        line_q  = r_byp ? r_byp_data : ram_q;
        up1     = line_q[PW-1:0];
        up2     = line_q[2*PW-1:PW];
        nc[0]   = up2;
        nc[1]   = up1;
        nc[2]   = r_s1_px;
        wr_en   = r_s1_valid && r_s1_pix;
        wr_data = {up1, r_s1_px};
        if (r_s1_pix) begin
            res.pixel_out = r_s1_border ? r_win_c2[1] :
                            gb3_pkg::blur_121(r_win_c1, r_win_c2, nc);
        end else begin
            res.pixel_out = r_s1_row1 ? up2 : up1;
        end
        res.end_of_frame = r_s1_eof;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_c0 <= '0;
            r_win_c1 <= '0;
            r_win_c2 <= '0;
        end else if (wr_en) begin
            r_win_c0 <= r_win_c1;
            r_win_c1 <= r_win_c2;
            r_win_c2 <= nc;
        end
    end

    // output queue; stall upstream when an in-flight result could not land, or during a geometry update
    assign push        = r_s1_valid && r_s1_emit;
    assign pop         = (r_cnt != '0) && !i_out_stall;
    assign occ         = {1'b0, r_cnt} + {{FC{1'b0}}, push};
    assign o_in_stall  = (r_state != gb3_pkg::S_RUN) || (occ >= (FC + 1)'(FD));
    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_fifo[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + FA'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FA'(1);
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + FC'(1);
                2'b01:   r_cnt <= r_cnt - FC'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `GB3_ASSERT_SAME(a_push_room, i_clk, i_rst_n, push, r_cnt < FC'(FD))
    `GB3_ASSERT_SAME(a_ocol_range, i_clk, i_rst_n, r_state == gb3_pkg::S_RUN, WW'(r_ocol) < w_eff)
    `GB3_ASSERT_NEXT(a_eof_wrap, i_clk, i_rst_n, acc_emit && eof_now, r_out_pos == '0)
    `GB3_ASSERT_NEXT(a_cfg_restart, i_clk, i_rst_n, cfg_wr, r_state == gb3_pkg::S_MUL)

endmodule
